@@ rtl/core/pol_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pol_pkg : shared definitions for the positional ordered list
// word layouts, operation and status codes, cell control types
// ----------------------------------------------------------------------------
package pol_pkg;

   // default list depth
   localparam int DEPTH_DEFAULT = 16;

   // field widths
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // word widths, padded to whole bytes
   localparam int REQ_W = 40;
   localparam int RSP_W = 104;

   // operation codes
   localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // cell update kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_HOLD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INS  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEL  = 2'd2;

   // broadcast control to every cell
   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] ins_value;
      logic                      search_en;
      logic signed [VALUE_W-1:0] search_value;
   } cell_ctrl_type;

   // partial result collected along the chain
   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] last_value;
      logic signed [VALUE_W-1:0] second_last_value;
   } col_type;

endpackage
`default_nettype wire

@@ rtl/core/pol_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pol_cell : one list slot
// holds one entry, shifts towards either neighbour on insert or delete and
// passes search and tail information one hop down the chain each cycle
// ----------------------------------------------------------------------------
module pol_cell #(
   parameter int IDX  = 0,
   parameter int IDXW = 4,
   parameter int CW   = 5
) (
   input  wire logic                                 clock,
   input  wire pol_pkg::cell_ctrl_type               ctrl,
   input  wire logic [IDXW-1:0]                      slot,
   input  wire logic [CW-1:0]                        count,
   input  wire logic signed [pol_pkg::VALUE_W-1:0]   left_value,
   input  wire logic signed [pol_pkg::VALUE_W-1:0]   right_value,
   input  wire pol_pkg::col_type                     col_right,
   output logic signed [pol_pkg::VALUE_W-1:0]        value_ff,
   output pol_pkg::col_type                          col_ff
);

   logic signed [pol_pkg::VALUE_W-1:0] value_in;
   pol_pkg::col_type                   col_in;
   logic                               above_slot;
   logic                               at_slot;
   logic                               is_live;
   logic                               is_last;
   logic                               is_second_last;

   // position of this slot against the broadcast slot and count
   assign above_slot     = IDXW'(IDX) > slot;
   assign at_slot        = IDXW'(IDX) == slot;
   assign is_live        = CW'(IDX) < count;
   assign is_last        = (CW + 1)'(count) == (CW + 1)'(IDX + 1);
   assign is_second_last = (CW + 1)'(count) == (CW + 1)'(IDX + 2);

   // entry update
   always_comb begin
      value_in = value_ff;
      unique case (ctrl.kind)
         pol_pkg::KIND_INS: begin
            if (above_slot) begin
               value_in = left_value;
            end else if (at_slot) begin
               value_in = ctrl.ins_value;
            end
         end
         pol_pkg::KIND_DEL: begin
            if (above_slot || at_slot) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // merge own contribution into the word coming from the right
   always_comb begin
      col_in       = col_right;
      col_in.found = col_right.found
                   | (ctrl.search_en && is_live && (value_ff == ctrl.search_value));
      if (is_last) begin
         col_in.last_value = value_ff;
      end
      if (is_second_last) begin
         col_in.second_last_value = value_ff;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      col_ff   <= col_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/positional_ordered_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_ordered_list : bounded ordered list of signed 32-bit values
// insert and delete at front, back or 1-based position, and value search,
// built as a chain of slot cells
// ----------------------------------------------------------------------------
//  channel  dir  handshake             tdata fields (low bit up)
//  req      in   req_tvalid/tready     op[2:0] value[34:3] position[39:35]
//  rsp      out  rsp_tvalid/tready     status found count first last second_last
//
//  a request runs from acceptance to its result word in two phases: first every
//  cell shifts at once, then the search flag and tail values travel one cell a
//  cycle down the chain; no new request is taken meanwhile, and the next is
//  taken the cycle after the result is registered.
//  a result still held by the receiver stalls the chain only when the next finishes.
//  reset clears the count and handshake state; cell contents stay undefined.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
   parameter int DEPTH = pol_pkg::DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // op[2:0], value[34:3], position[39:35]
   input  wire logic [pol_pkg::REQ_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // status[1:0], found[2], count[7:3], first_value[39:8],
   // last_value[71:40], second_last_value[103:72]
   output logic [pol_pkg::RSP_W-1:0]        rsp_tdata
);

   localparam int IDXW = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;

   localparam logic ST_IDLE    = 1'b0;
   localparam logic ST_COLLECT = 1'b1;

   logic                               state_ff, state_in;
   logic [CW-1:0]                      tick_ff, tick_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic                               search_ff, search_in;
   logic signed [pol_pkg::VALUE_W-1:0] search_value_ff, search_value_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pol_pkg::RSP_W-1:0]          rsp_data_ff, rsp_data_in;
   logic [pol_pkg::STATUS_W-1:0]       status_ff, status_in;

   logic [pol_pkg::OP_W-1:0]           req_op;
   logic signed [pol_pkg::VALUE_W-1:0] req_value;
   logic [pol_pkg::POS_W-1:0]          req_pos;
   logic                               req_accept;
   logic                               collect_done;
   logic                               list_full;
   logic                               list_empty;
   logic [CMPW-1:0]                    pos_w;
   logic [CMPW-1:0]                    count_w;
   logic [pol_pkg::KIND_W-1:0]         kind;
   logic [IDXW-1:0]                    slot;
   logic [pol_pkg::STATUS_W-1:0]       status_dec;
   logic [CW-1:0]                      count_dec;
   logic                               search_dec;

   pol_pkg::cell_ctrl_type             ctrl;
   logic signed [pol_pkg::VALUE_W-1:0] cell_value [DEPTH];
   pol_pkg::col_type                   col [DEPTH+1];
   logic signed [pol_pkg::VALUE_W-1:0] first_value;

   // request word fields
   assign req_op    = req_tdata[2:0];
   assign req_value = req_tdata[34:3];
   assign req_pos   = req_tdata[39:35];

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign collect_done = (state_ff == ST_COLLECT) && (tick_ff == CW'(DEPTH))
                       && (!rsp_valid_ff || rsp_tready);

   assign list_full  = (count_ff == CW'(DEPTH));
   assign list_empty = (count_ff == '0);
   assign pos_w      = CMPW'(req_pos);
   assign count_w    = CMPW'(count_ff);

   // request decode against the current count
   always_comb begin
      status_dec = pol_pkg::ST_OK;
      kind       = pol_pkg::KIND_HOLD;
      slot       = '0;
      count_dec  = count_ff;
      search_dec = 1'b0;
      case (req_op) inside
         pol_pkg::OP_INS_FIRST, pol_pkg::OP_INS_LAST, pol_pkg::OP_INS_AT: begin
            if (list_full) begin
               status_dec = pol_pkg::ST_FULL;
            end else if (req_op == pol_pkg::OP_INS_FIRST) begin
               kind      = pol_pkg::KIND_INS;
               count_dec = count_ff + CW'(1);
            end else if (req_op == pol_pkg::OP_INS_LAST) begin
               kind      = pol_pkg::KIND_INS;
               slot      = count_ff[IDXW-1:0];
               count_dec = count_ff + CW'(1);
            end else if ((pos_w == '0) || (pos_w > count_w + CMPW'(1))) begin
               status_dec = pol_pkg::ST_RANGE;
            end else begin
               kind      = pol_pkg::KIND_INS;
               slot      = IDXW'(pos_w - CMPW'(1));
               count_dec = count_ff + CW'(1);
            end
         end
         pol_pkg::OP_DEL_FIRST, pol_pkg::OP_DEL_LAST, pol_pkg::OP_DEL_AT: begin
            if (list_empty) begin
               status_dec = pol_pkg::ST_EMPTY;
            end else if (req_op == pol_pkg::OP_DEL_FIRST) begin
               kind      = pol_pkg::KIND_DEL;
               count_dec = count_ff - CW'(1);
            end else if (req_op == pol_pkg::OP_DEL_LAST) begin
               count_dec = count_ff - CW'(1);
            end else if ((pos_w == '0) || (pos_w > count_w)) begin
               status_dec = pol_pkg::ST_RANGE;
            end else begin
               kind      = pol_pkg::KIND_DEL;
               slot      = IDXW'(pos_w - CMPW'(1));
               count_dec = count_ff - CW'(1);
            end
         end
         pol_pkg::OP_SEARCH: begin
            search_dec = 1'b1;
         end
         default: begin
            status_dec = pol_pkg::ST_OK;
         end
      endcase
   end

   // broadcast control to the chain
   always_comb begin
      ctrl.kind         = req_accept ? kind : pol_pkg::KIND_HOLD;
      ctrl.ins_value    = req_value;
      ctrl.search_en    = search_ff;
      ctrl.search_value = search_value_ff;
   end

   assign col[DEPTH] = '0;

   // chain of slot cells
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [pol_pkg::VALUE_W-1:0] left_value;
      logic signed [pol_pkg::VALUE_W-1:0] right_value;

      if (gi == 0) begin : g_head
         assign left_value = '0;
      end else begin : g_body
         assign left_value = cell_value[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
         assign right_value = cell_value[gi];
      end else begin : g_inner
         assign right_value = cell_value[gi+1];
      end

      pol_cell #(
         .IDX  (gi),
         .IDXW (IDXW),
         .CW   (CW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .slot        (slot),
         .count       (count_ff),
         .left_value  (left_value),
         .right_value (right_value),
         .col_right   (col[gi+1]),
         .value_ff    (cell_value[gi]),
         .col_ff      (col[gi])
      );
   end

   assign first_value = (count_ff != '0) ? cell_value[0] : '0;

   // sequencing and result word
   always_comb begin
      state_in        = state_ff;
      tick_in         = tick_ff;
      count_in        = count_ff;
      search_in       = search_ff;
      search_value_in = search_value_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in        = ST_COLLECT;
               tick_in         = '0;
               count_in        = count_dec;
               search_in       = search_dec;
               search_value_in = req_value;
               status_in       = status_dec;
            end
         end
         ST_COLLECT: begin
            if (collect_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {col[0].second_last_value,
                               col[0].last_value,
                               first_value,
                               pol_pkg::COUNT_W'(count_ff),
                               col[0].found,
                               status_ff};
            end else if (tick_ff != CW'(DEPTH)) begin
               tick_in = tick_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         count_ff     <= '0;
         search_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         count_ff     <= count_in;
         search_ff    <= search_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      search_value_ff <= search_value_in;
      status_ff       <= status_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

@@ test/tb_positional_ordered_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list : self-checking bench for the positional ordered list
// a directed table covers the empty, range and extreme-value cases and
// the unused op code; random runs of fill, drain, mixed and noise requests
// follow. Every result word is checked field by field against its table row or
// an in-bench model of the list, with random gaps on both channels, one long
// receiver hold-off and one sender pause until the list has answered everything.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list;
   import pol_pkg::*;

   localparam int LIST_DEPTH     = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int TAIL_ITEMS     = 150;
   localparam int HOLD_AT        = 500;
   localparam int HOLD_ITEMS     = 40;
   localparam int PAUSE_AT       = 1100;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_REPORTS    = 10;

   // op code left unused by the block
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   // request word, laid out as req_tdata
   typedef struct packed {
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
      logic [OP_W-1:0]           op;
   } list_req_type;

   // result word, laid out as rsp_tdata
   typedef struct packed {
      logic signed [VALUE_W-1:0] second_last_value;
      logic signed [VALUE_W-1:0] last_value;
      logic signed [VALUE_W-1:0] first_value;
      logic [COUNT_W-1:0]        count;
      logic                      found;
      logic [STATUS_W-1:0]       status;
   } list_rsp_type;

   // one line of the directed table
   typedef struct packed {
      list_req_type rq;
      logic         typed;
      list_rsp_type rsp;
   } dir_row_type;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} mix_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   // op[2:0], value[34:3], position[39:35]
   logic [REQ_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // status[1:0], found[2], count[7:3], first_value[39:8],
   // last_value[71:40], second_last_value[103:72]
   logic [RSP_W-1:0]     rsp_tdata;

   // model of the list contents
   logic signed [VALUE_W-1:0] list_cells [LIST_DEPTH];
   int                        list_count;

   list_rsp_type expected_results [$];
   dir_row_type  dir_rows [$];

   int  mismatch_count;
   int  results_checked;
   int  items_sent;
   int  status_seen [4];
   int  full_hits;
   int  found_hits;
   int  quiet_cycles;
   bit  quiet_tail;
   bit  hold_asked;

   positional_ordered_list #(.DEPTH(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // apply one request to the list model and return the result it gives
   function automatic list_rsp_type apply_request(input list_req_type rq);
      list_rsp_type r;
      int slot;
      int i;
      r = '0;
      r.status = ST_OK;
      case (rq.op)
         OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
            if (list_count >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else if (rq.op == OP_INS_AT &&
                         (rq.position == 0 || int'(rq.position) > list_count + 1)) begin
               r.status = ST_RANGE;
            end else begin
               slot = (rq.op == OP_INS_FIRST) ? 0 :
                      (rq.op == OP_INS_LAST) ? list_count : int'(rq.position) - 1;
               for (i = list_count; i > slot; i--) list_cells[i] = list_cells[i-1];
               list_cells[slot] = rq.value;
               list_count++;
            end
         end
         OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
            if (list_count == 0) begin
               r.status = ST_EMPTY;
            end else if (rq.op == OP_DEL_AT &&
                         (rq.position == 0 || int'(rq.position) > list_count)) begin
               r.status = ST_RANGE;
            end else begin
               slot = (rq.op == OP_DEL_FIRST) ? 0 :
                      (rq.op == OP_DEL_LAST) ? list_count - 1 : int'(rq.position) - 1;
               for (i = slot; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
               list_count--;
            end
         end
         OP_SEARCH: begin
            for (i = 0; i < list_count; i++) begin
               if (list_cells[i] == rq.value) r.found = 1'b1;
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(list_count);
      if (list_count >= 1) begin
         r.first_value = list_cells[0];
         r.last_value  = list_cells[list_count-1];
      end
      if (list_count >= 2) r.second_last_value = list_cells[list_count-2];
      return r;
   endfunction

   // value mix: extremes, a narrow band so searches hit, and full range
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            default: return -1;
         endcase
      end else if (roll < 55) begin
         return $signed($urandom_range(0, 16)) - 8;
      end
      return $urandom;
   endfunction

   // random request, weighted by mix mode, mostly with legal positions
   function automatic list_req_type pick_request(input mix_mode_type mode);
      list_req_type rq;
      int roll;
      int ins_pct;
      int del_pct;
      rq.value    = pick_value();
      rq.position = $urandom_range(0, 31);
      if (mode == MODE_NOISE) begin
         rq.op = $urandom_range(0, 7);
         return rq;
      end
      case (mode)
         MODE_FILL:  begin ins_pct = 80; del_pct = 10; end
         MODE_DRAIN: begin ins_pct = 10; del_pct = 75; end
         default:    begin ins_pct = 40; del_pct = 35; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
         case ($urandom_range(0, 2))
            0: rq.op = OP_INS_FIRST;
            1: rq.op = OP_INS_LAST;
            default: rq.op = OP_INS_AT;
         endcase
         if ($urandom_range(0, 99) < 88) rq.position = $urandom_range(1, list_count + 1);
      end else if (roll < ins_pct + del_pct) begin
         case ($urandom_range(0, 2))
            0: rq.op = OP_DEL_FIRST;
            1: rq.op = OP_DEL_LAST;
            default: rq.op = OP_DEL_AT;
         endcase
         if (list_count > 0 && $urandom_range(0, 99) < 88)
            rq.position = $urandom_range(1, list_count);
      end else begin
         rq.op = OP_SEARCH;
         if (list_count > 0 && $urandom_range(0, 1) == 1)
            rq.value = list_cells[$urandom_range(0, list_count - 1)];
      end
      return rq;
   endfunction

   function automatic dir_row_type row(input logic [OP_W-1:0] op,
                                       input logic signed [VALUE_W-1:0] value,
                                       input logic [POS_W-1:0] position);
      dir_row_type d;
      d = '0;
      d.rq.op       = op;
      d.rq.value    = value;
      d.rq.position = position;
      return d;
   endfunction

   function automatic dir_row_type row_chk(input logic [OP_W-1:0] op,
                                           input logic signed [VALUE_W-1:0] value,
                                           input logic [POS_W-1:0] position,
                                           input logic [STATUS_W-1:0] status,
                                           input logic found,
                                           input logic [COUNT_W-1:0] count,
                                           input logic signed [VALUE_W-1:0] first,
                                           input logic signed [VALUE_W-1:0] last,
                                           input logic signed [VALUE_W-1:0] second_last);
      dir_row_type d;
      d = row(op, value, position);
      d.typed                 = 1'b1;
      d.rsp.status            = status;
      d.rsp.found             = found;
      d.rsp.count             = count;
      d.rsp.first_value       = first;
      d.rsp.last_value        = last;
      d.rsp.second_last_value = second_last;
      return d;
   endfunction

   // offer one word, wait for it to be taken, then log what it should return
   task automatic send_request(input list_req_type rq, input logic typed,
                               input list_rsp_type typed_rsp, input int idle_pct);
      list_rsp_type predicted;
      if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rq;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_request(rq);
      if (list_count == LIST_DEPTH && rq.op inside {OP_INS_FIRST, OP_INS_LAST, OP_INS_AT} &&
          predicted.status == ST_OK)
         full_hits++;
      if (predicted.found) found_hits++;
      status_seen[predicted.status]++;
      expected_results.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] want,
                                  input logic [VALUE_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, field, want, got);
   endtask

   // result checking against the oldest expectation
   always @(posedge clock) begin : rsp_check
      list_rsp_type got;
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_checked++;
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding (count)", '0, got.count);
         end else begin
            want = expected_results.pop_front();
            if (got.status != want.status) report_mismatch("status", want.status, got.status);
            if (got.found != want.found) report_mismatch("found", want.found, got.found);
            if (got.count != want.count) report_mismatch("count", want.count, got.count);
            if (got.first_value != want.first_value)
               report_mismatch("first_value", want.first_value, got.first_value);
            if (got.last_value != want.last_value)
               report_mismatch("last_value", want.last_value, got.last_value);
            if (got.second_last_value != want.second_last_value)
               report_mismatch("second_last_value", want.second_last_value,
                               got.second_last_value);
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver side: stretches with and without stall bursts, one long hold-off
   initial begin : rsp_side
      int stall_left;
      int stretch_left;
      int stall_pct;
      bit hold_started;
      stall_left   = 0;
      stretch_left = 0;
      stall_pct    = 0;
      hold_started = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_asked && !hold_started) begin
            hold_started = 1'b1;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0 && !quiet_tail) begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(40, 300);
               stall_pct    = ($urandom_range(0, 2) == 0) ? 0 : 12;
            end
            stretch_left--;
            if ($urandom_range(1, 100) <= stall_pct) stall_left = $urandom_range(1, 17);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // stimulus
   initial begin : stimulus
      mix_mode_type seg_mode;
      int           seg_left;
      int           idle_pct;
      int           n;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      list_count      = 0;
      mismatch_count  = 0;
      results_checked = 0;
      items_sent      = 0;
      full_hits       = 0;
      found_hits      = 0;
      status_seen     = '{default: 0};
      quiet_tail      = 1'b0;
      hold_asked      = 1'b0;

      // directed table: empty list errors, range errors, extremes, unused op
      dir_rows.push_back(row_chk(OP_SEARCH, 0, 1, ST_OK, 0, 0, 0, 0, 0));
      dir_rows.push_back(row_chk(OP_DEL_FIRST, 0, 1, ST_EMPTY, 0, 0, 0, 0, 0));
      dir_rows.push_back(row_chk(OP_DEL_LAST, -1, 1, ST_EMPTY, 0, 0, 0, 0, 0));
      // emptiness wins over a bad position
      dir_rows.push_back(row_chk(OP_DEL_AT, 0, 0, ST_EMPTY, 0, 0, 0, 0, 0));
      dir_rows.push_back(row_chk(OP_INS_AT, 5, 0, ST_RANGE, 0, 0, 0, 0, 0));
      dir_rows.push_back(row_chk(OP_INS_AT, 5, 2, ST_RANGE, 0, 0, 0, 0, 0));
      dir_rows.push_back(row_chk(OP_INS_FIRST, VAL_MAX, 1, ST_OK, 0, 1, VAL_MAX, VAL_MAX, 0));
      dir_rows.push_back(row_chk(OP_INS_LAST, VAL_MIN, 1, ST_OK, 0, 2,
                                 VAL_MAX, VAL_MIN, VAL_MAX));
      dir_rows.push_back(row_chk(OP_INS_AT, -1, 2, ST_OK, 0, 3, VAL_MAX, VAL_MIN, -1));
      dir_rows.push_back(row_chk(OP_UNUSED, -1, 31, ST_OK, 0, 3, VAL_MAX, VAL_MIN, -1));
      dir_rows.push_back(row_chk(OP_SEARCH, -1, 1, ST_OK, 1, 3, VAL_MAX, VAL_MIN, -1));
      dir_rows.push_back(row_chk(OP_SEARCH, 0, 1, ST_OK, 0, 3, VAL_MAX, VAL_MIN, -1));
      dir_rows.push_back(row_chk(OP_DEL_AT, 0, 0, ST_RANGE, 0, 3, VAL_MAX, VAL_MIN, -1));
      dir_rows.push_back(row_chk(OP_DEL_AT, 0, 4, ST_RANGE, 0, 3, VAL_MAX, VAL_MIN, -1));
      dir_rows.push_back(row_chk(OP_INS_AT, 0, 31, ST_RANGE, 0, 3, VAL_MAX, VAL_MIN, -1));
      dir_rows.push_back(row(OP_INS_AT, 32'sh5A5A_A5A5, 4));
      dir_rows.push_back(row(OP_DEL_AT, 0, 4));
      dir_rows.push_back(row_chk(OP_DEL_AT, 0, 2, ST_OK, 0, 2, VAL_MAX, VAL_MIN, VAL_MAX));
      dir_rows.push_back(row(OP_INS_FIRST, 0, 16));
      dir_rows.push_back(row(OP_DEL_FIRST, VAL_MIN, 16));
      dir_rows.push_back(row_chk(OP_DEL_LAST, 0, 1, ST_OK, 0, 1, VAL_MAX, VAL_MAX, 0));
      // deleting the only entry empties the list
      dir_rows.push_back(row_chk(OP_DEL_AT, 0, 1, ST_OK, 0, 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) send_request(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].rsp, 15);

      // random part, opened by a fill run so the list reaches full early
      seg_mode = MODE_FILL;
      seg_left = 40;
      idle_pct = 15;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2: seg_mode = MODE_FILL;
               3, 4, 5: seg_mode = MODE_DRAIN;
               6, 7, 8: seg_mode = MODE_MIXED;
               default: seg_mode = MODE_NOISE;
            endcase
            seg_left = $urandom_range(8, 40);
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
         end
         seg_left--;
         if (n == HOLD_AT) hold_asked = 1'b1;
         // let the list answer everything before going on
         if (n == PAUSE_AT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (expected_results.size() != 0) @(posedge clock);
         end
         if (n >= RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
         send_request(pick_request(seg_mode), 1'b0, '0,
                      (quiet_tail || (n >= HOLD_AT && n < HOLD_AT + HOLD_ITEMS)) ? 0 : idle_pct);
      end

      // drain
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 8) @(posedge clock);

      $display("run covered %0d requests and %0d results: ok %0d, full %0d, empty %0d, range %0d",
               items_sent, results_checked, status_seen[ST_OK], status_seen[ST_FULL],
               status_seen[ST_EMPTY], status_seen[ST_RANGE]);
      $display("list filled to the top %0d times, searches hit %0d times, %0d mismatches",
               full_hits, found_hits, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
